// ----- src/pdh_pkg.sv -----
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared types and constants of the pair distance histogram block.
// ----------------------------------------------------------------------------
package pdh_pkg;

    localparam int MAX_ATOMS = 4096;
    localparam int ATOM_AW   = $clog2(MAX_ATOMS);
    localparam int MAX_BINS  = 64;
    localparam int BIN_AW    = 6;
    localparam int COORD_W   = 24;
    localparam int ATOM_W    = 3 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int ROOT_W    = DIFF_W;
    localparam int COUNT_W   = 25;
    localparam int NA_W      = 13;
    localparam int NB_W      = 7;
    localparam int BW_W      = 24;
    localparam int STEP_W    = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_ATOMS = 2'd0;
    localparam logic [1:0] CFG_NUM_BINS  = 2'd1;
    localparam logic [1:0] CFG_BIN_WIDTH = 2'd2;

    // Input operation codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Result of the pair unit.
    typedef struct packed {
        logic               done;
        logic [ROOT_W-1:0]  quo;
    } pair_res_t;

endpackage

// ----- src/pdh_atom_ram.sv -----
// ----------------------------------------------------------------------------
// pdh_atom_ram
// Atom store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pdh_atom_ram (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [pdh_pkg::ATOM_AW-1:0]  waddr,
    input  logic [pdh_pkg::ATOM_W-1:0]   wdata,
    input  logic [pdh_pkg::ATOM_AW-1:0]  raddr,
    output logic [pdh_pkg::ATOM_W-1:0]   rdata
);

    logic [pdh_pkg::ATOM_W-1:0] mem [pdh_pkg::MAX_ATOMS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/pdh_pair.sv -----
// ----------------------------------------------------------------------------
// pdh_pair
// Distance bin of one atom pair: differences, squares, sum, a two-bit-per-step
// square root and a restoring divide by the bin width.
// ----------------------------------------------------------------------------
module pdh_pair (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pdh_pkg::ATOM_W-1:0]    atom_a,
    input  logic [pdh_pkg::ATOM_W-1:0]    atom_b,
    input  logic [pdh_pkg::BW_W-1:0]      bin_width,
    output pdh_pkg::pair_res_t            res
);

    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_SQ   = 5'b00010,
        P_SUM  = 5'b00100,
        P_SQRT = 5'b01000,
        P_DIV  = 5'b10000
    } pstate_t;

    pstate_t state_reg, state_next;
    logic [pdh_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [pdh_pkg::DIFF_W-1:0] d_reg [3];
    logic signed [pdh_pkg::DIFF_W-1:0] d_next [3];
    logic [pdh_pkg::SQ_W-1:0] sq_reg [3];
    logic [pdh_pkg::SQ_W-1:0] sq_next [3];
    logic [pdh_pkg::SQ_W-1:0] rad_reg, rad_next;
    logic [pdh_pkg::ROOT_W+1:0] rem_reg, rem_next;
    logic [pdh_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [pdh_pkg::BW_W-1:0] drem_reg, drem_next;
    logic done_reg, done_next;
    logic [pdh_pkg::ROOT_W+1:0] s_try, s_trial;
    logic [pdh_pkg::BW_W:0] d_try;
    logic signed [pdh_pkg::SQ_W-1:0] prod [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = d_reg[k] * d_reg[k];
        end
        s_try   = {rem_reg[pdh_pkg::ROOT_W-1:0], rad_reg[pdh_pkg::SQ_W-1 -: 2]};
        s_trial = {root_reg, 2'b01};
        d_try   = {drem_reg, root_reg[pdh_pkg::ROOT_W-1]};
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        drem_next  = drem_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            P_IDLE: begin
                if (start) begin
                    for (int k = 0; k < 3; k++) begin
                        d_next[k] =
                            pdh_pkg::DIFF_W'($signed(atom_a[k*pdh_pkg::COORD_W +:
                                                           pdh_pkg::COORD_W]))
                          - pdh_pkg::DIFF_W'($signed(atom_b[k*pdh_pkg::COORD_W +:
                                                           pdh_pkg::COORD_W]));
                    end
                    state_next = P_SQ;
                end
            end
            P_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    sq_next[k] = prod[k];
                end
                state_next = P_SUM;
            end
            P_SUM: begin
                rad_next   = sq_reg[0] + sq_reg[1] + sq_reg[2];
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = P_SQRT;
            end
            P_SQRT: begin
                rad_next = {rad_reg[pdh_pkg::SQ_W-3:0], 2'b00};
                if (s_try >= s_trial) begin
                    rem_next  = s_try - s_trial;
                    root_next = {root_reg[pdh_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = s_try;
                    root_next = {root_reg[pdh_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == pdh_pkg::STEP_W'(pdh_pkg::ROOT_W - 1)) begin
                    step_next  = '0;
                    drem_next  = '0;
                    state_next = P_DIV;
                end
            end
            P_DIV: begin
                // Root register doubles as the dividend and quotient shifter.
                if (d_try >= {1'b0, bin_width}) begin
                    drem_next = pdh_pkg::BW_W'(d_try - {1'b0, bin_width});
                    root_next = {root_reg[pdh_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    drem_next = d_try[pdh_pkg::BW_W-1:0];
                    root_next = {root_reg[pdh_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == pdh_pkg::STEP_W'(pdh_pkg::ROOT_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = P_IDLE;
                end
            end
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        step_reg <= step_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        drem_reg <= drem_next;
    end

    assign res.done = done_reg;
    assign res.quo  = root_reg;

endmodule

// ----- src/pair_distance_histogram.sv -----
// ----------------------------------------------------------------------------
// pair_distance_histogram
// Loads atoms into a store and bins the distances of all ordered atom pairs.
// ----------------------------------------------------------------------------
// Sequence: a load word writes one atom into the store. A compute word clears
// the histogram, then runs each unordered pair through the pair unit, with a
// bin read and write when its bin is in use and an extra atom read at the
// start of each row, then emits the bins; one input word is taken at a time.
// Reset: synchronous, active low; state, valid and configuration registers
// reset, the atom store keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
module pair_distance_histogram (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // atom_index[11:0], pos_x, pos_y, pos_z, zero pad
    input  logic [0:0]  s_tuser,  // op
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // bin_index[5:0], pair_count[30:6], zero pad
    output logic        m_tlast,  // last_bin
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLEAR = 10'b0000000010,
        ST_RDI   = 10'b0000000100,
        ST_RDJ   = 10'b0000001000,
        ST_START = 10'b0000010000,
        ST_CALC  = 10'b0000100000,
        ST_HRD   = 10'b0001000000,
        ST_HWR   = 10'b0010000000,
        ST_ERD   = 10'b0100000000,
        ST_ELD   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers as written and the clamped copies for a run.
    logic [pdh_pkg::NA_W-1:0] cfg_na_reg;
    logic [pdh_pkg::NB_W-1:0] cfg_nb_reg;
    logic [pdh_pkg::BW_W-1:0] cfg_bw_reg;
    logic [pdh_pkg::NA_W-1:0] na_reg, na_next;
    logic [pdh_pkg::NB_W-1:0] nb_reg, nb_next;
    logic [pdh_pkg::BW_W-1:0] bw_reg, bw_next;

    // Pair walk indexes; they can hold the atom count itself.
    logic [pdh_pkg::NA_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [pdh_pkg::NB_W-1:0] k_reg, k_next;
    logic [pdh_pkg::BIN_AW-1:0] bin_reg, bin_next;
    logic [pdh_pkg::ATOM_W-1:0] ai_reg, ai_next;

    // Atom store ports.
    logic                        ram_we;
    logic [pdh_pkg::ATOM_AW-1:0] ram_raddr;
    logic [pdh_pkg::ATOM_W-1:0]  ram_rdata;

    // Histogram memory.
    logic [pdh_pkg::COUNT_W-1:0] hist_mem [pdh_pkg::MAX_BINS];
    logic                        hist_we;
    logic [pdh_pkg::BIN_AW-1:0]  hist_waddr, hist_raddr;
    logic [pdh_pkg::COUNT_W-1:0] hist_wdata, hist_rdata_reg;

    // Output register.
    logic                        mv_reg, mv_next;
    logic [31:0]                 md_reg, md_next;
    logic                        ml_reg, ml_next;
    logic                        out_free;

    pdh_pkg::pair_res_t          pair_res;
    logic                        pair_start;
    logic                        in_acc;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_na_reg <= pdh_pkg::NA_W'(1);
            cfg_nb_reg <= pdh_pkg::NB_W'(pdh_pkg::MAX_BINS);
            cfg_bw_reg <= pdh_pkg::BW_W'(256);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pdh_pkg::CFG_NUM_ATOMS: cfg_na_reg <= cfg_data[pdh_pkg::NA_W-1:0];
                pdh_pkg::CFG_NUM_BINS:  cfg_nb_reg <= cfg_data[pdh_pkg::NB_W-1:0];
                pdh_pkg::CFG_BIN_WIDTH: cfg_bw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pdh_atom_ram u_atom_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_tdata[pdh_pkg::ATOM_AW-1:0]),
        .wdata (s_tdata[12 +: pdh_pkg::ATOM_W]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pdh_pair u_pair (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pair_start),
        .atom_a    (ai_reg),
        .atom_b    (ram_rdata),
        .bin_width (bw_reg),
        .res       (pair_res)
    );

    // The main sequencer: clear, walk the pairs, then emit the bins.
    always_comb begin
        state_next = state_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        bw_next    = bw_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        bin_next   = bin_reg;
        ai_next    = ai_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        ram_we     = 1'b0;
        ram_raddr  = i_reg[pdh_pkg::ATOM_AW-1:0];
        hist_we    = 1'b0;
        hist_waddr = bin_reg;
        hist_raddr = bin_reg;
        hist_wdata = '0;
        pair_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser[0] == pdh_pkg::OP_LOAD) begin
                        ram_we = 1'b1;
                    end else begin
                        // Clamp the configuration for this run.
                        na_next = (cfg_na_reg > pdh_pkg::NA_W'(pdh_pkg::MAX_ATOMS))
                                ? pdh_pkg::NA_W'(pdh_pkg::MAX_ATOMS) : cfg_na_reg;
                        nb_next = (cfg_nb_reg == '0) ? pdh_pkg::NB_W'(1)
                                : (cfg_nb_reg > pdh_pkg::NB_W'(pdh_pkg::MAX_BINS))
                                ? pdh_pkg::NB_W'(pdh_pkg::MAX_BINS) : cfg_nb_reg;
                        bw_next = (cfg_bw_reg == '0) ? pdh_pkg::BW_W'(1) : cfg_bw_reg;
                        k_next  = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                // Bin 0 starts with the self pairs, one per atom.
                hist_we    = 1'b1;
                hist_waddr = k_reg[pdh_pkg::BIN_AW-1:0];
                hist_wdata = (k_reg == '0) ? pdh_pkg::COUNT_W'(na_reg) : '0;
                k_next     = k_reg + 1'b1;
                if (k_reg == pdh_pkg::NB_W'(pdh_pkg::MAX_BINS - 1)) begin
                    k_next = '0;
                    i_next = '0;
                    j_next = pdh_pkg::NA_W'(1);
                    state_next = (na_reg >= pdh_pkg::NA_W'(2)) ? ST_RDI : ST_ERD;
                end
            end
            ST_RDI: begin
                ram_raddr  = i_reg[pdh_pkg::ATOM_AW-1:0];
                state_next = ST_RDJ;
            end
            ST_RDJ: begin
                ram_raddr  = j_reg[pdh_pkg::ATOM_AW-1:0];
                if (j_reg == i_reg + 1'b1) begin
                    ai_next = ram_rdata;
                end
                state_next = ST_START;
            end
            ST_START: begin
                pair_start = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (pair_res.done) begin
                    bin_next = pair_res.quo[pdh_pkg::BIN_AW-1:0];
                    if (pair_res.quo < pdh_pkg::ROOT_W'(nb_reg)) begin
                        state_next = ST_HRD;
                    end else if (j_reg + 1'b1 < na_reg) begin
                        j_next = j_reg + 1'b1;
                        state_next = ST_RDJ;
                    end else if (i_reg + pdh_pkg::NA_W'(2) < na_reg) begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + pdh_pkg::NA_W'(2);
                        state_next = ST_RDI;
                    end else begin
                        state_next = ST_ERD;
                    end
                end
            end
            ST_HRD: begin
                hist_raddr = bin_reg;
                state_next = ST_HWR;
            end
            ST_HWR: begin
                // Each unordered pair counts for both orders, with saturation.
                hist_we    = 1'b1;
                hist_waddr = bin_reg;
                hist_wdata = (hist_rdata_reg > pdh_pkg::COUNT_MAX - pdh_pkg::COUNT_W'(2))
                           ? pdh_pkg::COUNT_MAX : hist_rdata_reg + pdh_pkg::COUNT_W'(2);
                if (j_reg + 1'b1 < na_reg) begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_RDJ;
                end else if (i_reg + pdh_pkg::NA_W'(2) < na_reg) begin
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + pdh_pkg::NA_W'(2);
                    state_next = ST_RDI;
                end else begin
                    state_next = ST_ERD;
                end
            end
            ST_ERD: begin
                hist_raddr = k_reg[pdh_pkg::BIN_AW-1:0];
                if (out_free) begin
                    state_next = ST_ELD;
                end
            end
            ST_ELD: begin
                mv_next = 1'b1;
                md_next = {1'b0, hist_rdata_reg, k_reg[pdh_pkg::BIN_AW-1:0]};
                ml_next = (k_reg + 1'b1 == nb_reg);
                k_next  = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 == nb_reg) ? ST_IDLE : ST_ERD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        na_reg  <= na_next;
        nb_reg  <= nb_next;
        bw_reg  <= bw_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        bin_reg <= bin_next;
        ai_reg  <= ai_next;
        md_reg  <= md_next;
        ml_reg  <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    // The pair unit only reports a result while the sequencer waits for one.
    a_pair_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_res.done |-> state_reg == ST_CALC)
        else $error("pair result outside of the wait state");

    // Loading a bin into the output register always presents a word.
    a_load_shows_word: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ELD |=> m_tvalid)
        else $error("loaded bin not presented");

    // A count update never wraps below the value read.
    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HWR |-> hist_wdata >= hist_rdata_reg)
        else $error("histogram count wrapped");

endmodule

// ----- verif/tb_pair_distance_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pair_distance_histogram
// Self-checking bench for the pair distance histogram block. Atom loads and
// compute words are driven on the input stream, registers are changed between
// phases, and every histogram word is compared against an internal predictor.
// ----------------------------------------------------------------------------
module tb_pair_distance_histogram;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 10000;

    typedef struct {
        logic              op;
        logic [11:0]       slot;
        logic [23:0]       px;
        logic [23:0]       py;
        logic [23:0]       pz;
        int                first_count;  // expected bin 0 count, -1 if not typed in
    } atom_word_t;

    typedef struct packed {
        logic [5:0]  bin;
        logic [24:0] count;
        logic        last;
    } bin_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    pair_distance_histogram dut (.*);

    // Predictor state: its own copy of the store and the registers.
    logic signed [23:0] atom_x [pdh_pkg::MAX_ATOMS];
    logic signed [23:0] atom_y [pdh_pkg::MAX_ATOMS];
    logic signed [23:0] atom_z [pdh_pkg::MAX_ATOMS];
    bit                 atom_loaded [pdh_pkg::MAX_ATOMS];
    logic [12:0]        reg_atoms;
    logic [6:0]         reg_bins;
    logic [23:0]        reg_width;

    bin_word_t expected_bins[$];
    int  typed_bin0[$];
    int  errors = 0;
    int  bins_seen = 0;
    int  computes_sent;
    int  cycles = 0;
    bit  hold_receiver;
    bit  random_stall;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_pair_distance_histogram: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s at word %0d: got %0d, expected %0d", what, bins_seen, got,
                 want);
        errors++;
    endtask

    function automatic logic [24:0] floor_sqrt(input logic [49:0] n);
        logic [49:0] root;
        logic [49:0] trial;
        root = '0;
        for (int b = 24; b >= 0; b--) begin
            trial = root | (50'd1 << b);
            if (trial * trial <= n) root = trial;
        end
        return root[24:0];
    endfunction

    // Works out the whole histogram of one compute word.
    task automatic predict_histogram();
        int unsigned na;
        int unsigned nb;
        logic [23:0] bw;
        logic [24:0] counts [pdh_pkg::MAX_BINS];
        logic signed [24:0] dx, dy, dz;
        logic [49:0] d2;
        logic [24:0] root_len;
        logic [24:0] bin;
        bin_word_t w;
        na = (reg_atoms > pdh_pkg::MAX_ATOMS) ? pdh_pkg::MAX_ATOMS : reg_atoms;
        nb = (reg_bins == 0) ? 1
           : ((reg_bins > pdh_pkg::MAX_BINS) ? pdh_pkg::MAX_BINS : reg_bins);
        bw = (reg_width == 0) ? 24'd1 : reg_width;
        foreach (counts[k]) counts[k] = '0;
        for (int i = 0; i < na; i++) begin
            if (counts[0] != pdh_pkg::COUNT_MAX) counts[0]++;
            for (int j = i + 1; j < na; j++) begin
                dx = atom_x[i] - atom_x[j];
                dy = atom_y[i] - atom_y[j];
                dz = atom_z[i] - atom_z[j];
                d2 = 50'(dx * dx) + 50'(dy * dy) + 50'(dz * dz);
                root_len = floor_sqrt(d2);
                bin = root_len / bw;
                if (bin < nb)
                    counts[bin] = (pdh_pkg::COUNT_MAX - counts[bin] < 2)
                                ? pdh_pkg::COUNT_MAX : counts[bin] + 2;
            end
        end
        for (int k = 0; k < nb; k++) begin
            w.bin = k[5:0];
            w.count = counts[k];
            w.last = (k + 1 == nb);
            expected_bins.push_back(w);
        end
    endtask

    // The sender: drives one word and waits for its handshake. The valid
    // line stays high into a following word when there is no gap.
    task automatic send_word(input atom_word_t a);
        int gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40));
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= a.op;
        s_tdata  <= {16'd0, a.pz, a.py, a.px, a.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (a.op == pdh_pkg::OP_LOAD) begin
            atom_x[a.slot] = a.px;
            atom_y[a.slot] = a.py;
            atom_z[a.slot] = a.pz;
            atom_loaded[a.slot] = 1'b1;
        end else begin
            typed_bin0.push_back(a.first_count);
            predict_histogram();
            computes_sent++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            pdh_pkg::CFG_NUM_ATOMS: reg_atoms = val[12:0];
            pdh_pkg::CFG_NUM_BINS:  reg_bins  = val[6:0];
            pdh_pkg::CFG_BIN_WIDTH: reg_width = val;
            default: ;
        endcase
    endtask

    // Waits until every histogram word has arrived, then lets the block settle.
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic atom_word_t load_of(input int slot, input int x, input int y,
                                           input int z);
        atom_word_t a;
        a.op = pdh_pkg::OP_LOAD;
        a.slot = slot[11:0];
        a.px = x[23:0];
        a.py = y[23:0];
        a.pz = z[23:0];
        a.first_count = -1;
        return a;
    endfunction

    function automatic atom_word_t compute_of(input int bin0);
        atom_word_t a;
        a = load_of($urandom, $urandom, $urandom, $urandom);
        a.op = pdh_pkg::OP_COMPUTE;
        a.first_count = bin0;
        return a;
    endfunction

    function automatic atom_word_t random_atom(input int top_slot);
        int mag;
        mag = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'h0007FF;
        return load_of($urandom_range(0, top_slot), $urandom & mag, $urandom & mag,
                       $urandom & mag);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn || hold_receiver) begin
            m_tready <= 1'b0;
        end else if (random_stall) begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Checker of each accepted histogram word.
    always @(posedge aclk) begin
        bin_word_t want;
        int bin0;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bins.size() == 0) begin
                $display("unexpected histogram word bin %0d", m_tdata[5:0]);
                errors++;
            end else begin
                want = expected_bins.pop_front();
                if (want.bin == 0) begin
                    bin0 = typed_bin0.pop_front();
                    if (bin0 >= 0 && m_tdata[30:6] != bin0)
                        report_mismatch("typed bin 0 count", m_tdata[30:6], bin0);
                end
                if (m_tdata[5:0] != want.bin)
                    report_mismatch("bin_index", m_tdata[5:0], want.bin);
                if (m_tdata[30:6] != want.count)
                    report_mismatch("pair_count", m_tdata[30:6], want.count);
                if (m_tlast != want.last)
                    report_mismatch("last_bin", m_tlast, want.last);
                if (m_tdata[31] !== 1'b0)
                    report_mismatch("pad bit", m_tdata[31], 0);
                bins_seen++;
            end
        end
    end

    // Directed rows: a few atoms at the coordinate extremes, then computes
    // under several register settings. A bin 0 count is typed in where it is
    // obvious (a single atom, or all atoms coincide).
    atom_word_t directed [] = '{
        load_of(0, 0, 0, 0),
        load_of(1, 0, 0, 0),
        load_of(4095, 24'h7FFFFF, 24'h800000, 24'h7FFFFF),
        compute_of(1),
        load_of(2, 0, 0, 0),
        load_of(3, 24'h800000, 24'h7FFFFF, 24'h800000),
        load_of(4, 24'h7FFFFF, 24'h800000, 24'hFFFFFF),
        load_of(5, 256, -256, 512),
        compute_of(-1),
        compute_of(-1)
    };

    initial begin
        atom_word_t a;
        int top;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_receiver = 1'b0;
        random_stall = 1'b0;
        computes_sent = 0;
        reg_atoms = 13'd1;
        reg_bins = 7'd64;
        reg_width = 24'd256;
        foreach (atom_loaded[k]) atom_loaded[k] = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one atom, 64 bins, width 256.
        for (int r = 0; r < 4; r++) send_word(directed[r]);
        drain();
        // Two coincident atoms with a single bin: both orders plus self pairs.
        write_reg(pdh_pkg::CFG_NUM_ATOMS, 24'd2);
        write_reg(pdh_pkg::CFG_NUM_BINS, 24'd1);
        send_word(compute_of(4));
        drain();
        // Zero atoms, zero bins, zero width.
        write_reg(pdh_pkg::CFG_NUM_ATOMS, 24'd0);
        write_reg(pdh_pkg::CFG_NUM_BINS, 24'd0);
        write_reg(pdh_pkg::CFG_BIN_WIDTH, 24'd0);
        send_word(compute_of(0));
        drain();
        random_stall = 1'b1;
        for (int r = 4; r < 8; r++) send_word(directed[r]);
        // Extreme separations; with the maximum width only the two opposite
        // corner atoms land past bin 0.
        write_reg(pdh_pkg::CFG_NUM_ATOMS, 24'd6);
        write_reg(pdh_pkg::CFG_NUM_BINS, 24'd127);
        write_reg(pdh_pkg::CFG_BIN_WIDTH, 24'hFFFFFF);
        send_word(compute_of(-1));
        drain();
        write_reg(pdh_pkg::CFG_BIN_WIDTH, 24'd1);
        send_word(directed[8]);
        drain();
        write_reg(pdh_pkg::CFG_NUM_BINS, 24'd64);
        write_reg(pdh_pkg::CFG_BIN_WIDTH, 24'h040000);
        send_word(directed[9]);
        drain();

        // Random phases: load a small set of slots, then compute over them.
        for (int phase = 0; phase < 7; phase++) begin
            top = $urandom_range(2, 12);
            for (int k = 0; k <= top; k++) send_word(random_atom(k));
            for (int k = 0; k <= top; k++)
                if (!atom_loaded[k]) send_word(load_of(k, $urandom, $urandom, $urandom));
            write_reg(pdh_pkg::CFG_NUM_ATOMS, 24'(top + 1 - $urandom_range(0, 1)));
            write_reg(pdh_pkg::CFG_NUM_BINS, 24'($urandom_range(1, 64)));
            write_reg(pdh_pkg::CFG_BIN_WIDTH, 24'($urandom_range(1, 24'h008000)));
            if (phase == 3) begin
                // Long receiver hold-off while computes keep coming.
                fork
                    begin
                        hold_receiver = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_receiver = 1'b0;
                    end
                    begin
                        send_word(compute_of(-1));
                        send_word(compute_of(-1));
                        send_word(compute_of(-1));
                    end
                join
            end else begin
                send_word(compute_of(-1));
            end
            // Sender pauses until all histogram words are back.
            drain();
        end

        $display("covered %0d compute words and %0d histogram words,", computes_sent,
                 bins_seen);
        $display("with register extremes, coordinate extremes and receiver stalls");
        if (errors == 0) begin
            $display("tb_pair_distance_histogram: PASS");
        end else begin
            $display("tb_pair_distance_histogram: FAIL");
        end
        $finish;
    end
endmodule
